// ----- hdl/fbsp_pkg.sv -----
package fbsp_pkg;

	// byte and length widths fixed by the serial format
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 8;
	localparam int FLEN_W   = 6;
	localparam int STATUS_W = 2;
	localparam int PHASE_W  = 3;

	// register indexes of the configuration port
	localparam logic CFG_START = 1'b0;
	localparam logic CFG_END   = 1'b1;

	localparam logic [BYTE_W-1:0] START_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] END_RST   = 8'h55;

	// parser phases
	localparam logic [PHASE_W-1:0] PH_HUNT  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LEN   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SUM   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_END   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DRAIN = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SUM_ERR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_END_ERR = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FLEN_W-1:0]   frame_length;
		logic                data_valid;
		logic [BYTE_W-1:0]   payload_byte;
		logic                last;
	} result_t;

endpackage

// ----- hdl/fbsp_frame_mem.sv -----
module fbsp_frame_mem
	import fbsp_pkg::*;
#(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read; hold the word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/framed_byte_stream_parser.sv -----
// Framed byte stream parser.
//
// Input channel: one received byte per item on rx_byte (in_valid / in_stall).
// Frame format: start marker, length byte, payload bytes, 8-bit wrapping sum
// of the payload, end marker. Bytes outside a frame are dropped silently.
// Output channel (out_valid / out_stall): status, frame_length, data_valid,
// payload_byte and last, held in an output register.
// Results: a single-result item (length error, checksum error, end byte
// error, empty good frame) shows its result in the cycle after the byte that
// closes it is accepted. A good frame's payload bytes are replayed from the
// frame buffer after the end marker, each byte passing the buffer read register
// and the output register, one byte per cycle unless the receiver stalls.
// Throughput: one byte per cycle while parsing; the input is stalled during a
// drain, and whenever the output register is full and the receiver stalls.
// The frame buffer is a single synchronous memory (one write, one read port,
// registered read); writes happen only while collecting payload and reads only
// while draining, so the two never touch the same entry at once.
// Reset: parser hunts for the start marker, markers return to 0xAA and 0x55,
// output register empties. The buffer is not cleared; every entry that is
// read back was written by the current frame.
module framed_byte_stream_parser
	import fbsp_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// byte input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BYTE_W-1:0]   rx_byte,
	// results
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [FLEN_W-1:0]   frame_length,
	output logic                data_valid,
	output logic [BYTE_W-1:0]   payload_byte,
	output logic                last,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [BYTE_W-1:0]   cfg_data
);

	localparam int ADDR_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

	// configuration registers
	logic [BYTE_W-1:0] start_q, end_q;

	// parser state
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   pos_q, pos_d;
	logic [BYTE_W-1:0]  sum_q, sum_d;

	// drain control
	logic [LEN_W-1:0]   rd_idx_q;
	logic               rd_pend_q;
	logic               rd_last_q;
	logic               rd_issue;
	logic               drain_load;
	logic [BYTE_W-1:0]  rd_data;

	// output register
	logic               out_valid_q;
	result_t            out_q;
	logic               out_free;
	logic               in_acc;
	logic               res_load;
	result_t            res_d;
	logic               mem_we;
	logic [LEN_W-1:0]   pos_inc;

	assign out_free = !out_valid_q || !out_stall;
	// take no byte while draining or while a result could not be stored
	assign in_stall = (phase_q == PH_DRAIN) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			end_q   <= END_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START: start_q <= cfg_data;
				CFG_END:   end_q   <= cfg_data;
				default:   start_q <= start_q;
			endcase
		end
	end

	assign pos_inc = pos_q + LEN_W'(1);

	// byte parser: next phase and any single result
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		pos_d    = pos_q;
		sum_d    = sum_q;
		res_load = 1'b0;
		res_d    = '{status: ST_OK, frame_length: '0, data_valid: 1'b0,
			payload_byte: '0, last: 1'b1};
		mem_we   = 1'b0;
		if (in_acc) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == start_q) begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					if (LEN_W'(rx_byte) <= MAX_LEN) begin
						len_d   = LEN_W'(rx_byte);
						pos_d   = '0;
						sum_d   = '0;
						phase_d = (rx_byte == '0) ? PH_SUM : PH_DATA;
					end else begin
						res_load     = 1'b1;
						res_d.status = ST_LEN_ERR;
						phase_d      = PH_HUNT;
					end
				end
				PH_DATA: begin
					mem_we = 1'b1;
					pos_d  = pos_inc;
					sum_d  = sum_q + rx_byte;
					if (pos_inc >= len_q) begin
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					if (rx_byte == sum_q) begin
						phase_d = PH_END;
					end else begin
						res_load           = 1'b1;
						res_d.status       = ST_SUM_ERR;
						res_d.frame_length = len_q[FLEN_W-1:0];
						phase_d            = PH_HUNT;
					end
				end
				PH_END: begin
					phase_d = PH_HUNT;
					if (rx_byte != end_q) begin
						res_load           = 1'b1;
						res_d.status       = ST_END_ERR;
						res_d.frame_length = len_q[FLEN_W-1:0];
					end else if (len_q == '0) begin
						res_load = 1'b1;
					end else begin
						// replay the payload from the buffer
						phase_d = PH_DRAIN;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end else if (phase_q == PH_DRAIN) begin
			if (drain_load && rd_last_q) begin
				phase_d = PH_HUNT;
			end
		end else if (phase_q > PH_DRAIN) begin
			phase_d = PH_HUNT;
		end
	end

	// drain: one read in flight, advance when the output register frees up
	assign drain_load = rd_pend_q && out_free;
	assign rd_issue   = (phase_q == PH_DRAIN) && (rd_idx_q < len_q) &&
		(!rd_pend_q || drain_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			len_q     <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			sum_q   <= sum_d;
			if (phase_q != PH_DRAIN) begin
				rd_idx_q  <= '0;
				rd_pend_q <= 1'b0;
				rd_last_q <= 1'b0;
			end else if (rd_issue) begin
				rd_idx_q  <= rd_idx_q + LEN_W'(1);
				rd_pend_q <= 1'b1;
				rd_last_q <= (rd_idx_q == len_q - LEN_W'(1));
			end else if (drain_load) begin
				rd_pend_q <= 1'b0;
			end
		end
	end

	fbsp_frame_mem #(
		.DEPTH  (MAX_FRAME_BYTES),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (pos_q[ADDR_W-1:0]),
		.wr_data (rx_byte),
		.rd_en   (rd_issue),
		.rd_addr (rd_idx_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// output register: hold while stalled, load a parser or drain result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load || drain_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res_d;
		end else if (drain_load) begin
			out_q <= '{status: ST_OK, frame_length: len_q[FLEN_W-1:0],
				data_valid: 1'b1, payload_byte: rd_data, last: rd_last_q};
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign frame_length = out_q.frame_length;
	assign data_valid   = out_q.data_valid;
	assign payload_byte = out_q.payload_byte;
	assign last         = out_q.last;

	// no byte is taken while the buffer is replayed
	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DRAIN) |-> in_stall)
		else $error("input accepted during drain");

	// a buffer read is only ever in flight while draining
	a_read_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (phase_q == PH_DRAIN))
		else $error("buffer read outside drain");

	// payload results belong to good frames only
	a_payload_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.data_valid) |-> (out_q.status == ST_OK))
		else $error("payload byte with error status");

	// parser and drain never load the output register together
	a_single_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_load && drain_load))
		else $error("two result sources in one cycle");

endmodule
